[sv/interval_set_tracker_unit_macros.svh]
// assertion macros for the interval set tracker checker
`ifndef INTERVAL_SET_TRACKER_UNIT_MACROS_SVH
`define INTERVAL_SET_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define IST_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ist assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define IST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ist assertion failed");

`endif

[sv/ist_pkg.sv]
// ----------------------------------------------------------------------------
// ist_pkg
// types and codes shared by the interval set tracker files
// ----------------------------------------------------------------------------
package ist_pkg;

	localparam int ADDR_W = 63;
	localparam int SIZE_W = 33;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_WALK  = 2'd1,
		MODE_TRUNC = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} st_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_TRUNC,
		S_WSKIP,
		S_WLOOP,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		COP_HOLD,
		COP_MERGE,
		COP_INSERT,
		COP_TRUNC
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		addr_t    opb;
		addr_t    ope;
	} cell_cmd_t;

	typedef struct packed {
		addr_t b;
		addr_t e;
		logic  nb;
		logic  touch;
	} cell_link_t;

	localparam cell_link_t EDGE_LINK = '{b: '0, e: '0, nb: 1'b0, touch: 1'b0};

endpackage

[sv/ist_in_if.sv]
// ----------------------------------------------------------------------------
// ist_in_if
// request channel of the interval set tracker
// ----------------------------------------------------------------------------
interface ist_in_if import ist_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	addr_t             offset;
	logic [SIZE_W-1:0] size;

	modport source (output valid, mode, offset, size, input ready);
	modport sink (input valid, mode, offset, size, output ready);

endinterface

[sv/ist_out_if.sv]
// ----------------------------------------------------------------------------
// ist_out_if
// result channel of the interval set tracker
// ----------------------------------------------------------------------------
interface ist_out_if import ist_pkg::*; ();

	logic       valid;
	logic       ready;
	addr_t      seg_begin;
	addr_t      seg_end;
	logic       covered;
	logic       last;
	logic [1:0] status;

	modport source (output valid, seg_begin, seg_end, covered, last, status, input ready);
	modport sink (input valid, seg_begin, seg_end, covered, last, status, output ready);

endinterface

[sv/ist_cell.sv]
// ----------------------------------------------------------------------------
// ist_cell
// one table entry; compares against the operand and trades with its neighbors
// ----------------------------------------------------------------------------
module ist_cell import ist_pkg::*; (
	input  logic       clk,
	input  cell_cmd_t  cmd,
	input  logic       valid,
	input  cell_link_t left,
	input  cell_link_t right,
	input  logic       shrink_in,
	output logic       shrink_out,
	input  logic       tany_in,
	output logic       tany_out,
	output cell_link_t self
);

	addr_t           b_q;
	addr_t           e_q;
	logic [ADDR_W:0] e_inc;
	logic [ADDR_W:0] ope_inc;
	logic            below;
	logic            touch;
	logic            first;

	assign e_inc   = {1'b0, e_q} + (ADDR_W+1)'(1);
	assign ope_inc = {1'b0, cmd.ope} + (ADDR_W+1)'(1);
	assign below   = valid && (e_inc < {1'b0, cmd.opb});
	assign touch   = valid && !below && !(ope_inc < {1'b0, b_q});
	assign first   = touch && !left.touch;

	assign shrink_out = shrink_in || (first && right.touch);
	assign tany_out   = tany_in || touch;

	assign self.b     = b_q;
	assign self.e     = e_q;
	assign self.nb    = !below;
	assign self.touch = touch;

	always_ff @(posedge clk) begin
		case (cmd.op)
			COP_MERGE: begin
				if (first) begin
					b_q <= (cmd.opb < b_q) ? cmd.opb : b_q;
					if (right.touch) begin
						e_q <= (cmd.ope > right.e) ? cmd.ope : right.e;
					end else begin
						e_q <= (cmd.ope > e_q) ? cmd.ope : e_q;
					end
				end else if (shrink_in) begin
					b_q <= right.b;
					e_q <= right.e;
				end
			end
			COP_INSERT: begin
				if (!below && left.nb) begin
					b_q <= left.b;
					e_q <= left.e;
				end else if (!below) begin
					b_q <= cmd.opb;
					e_q <= cmd.ope;
				end
			end
			COP_TRUNC: begin
				if (valid && b_q <= cmd.opb && e_q > cmd.opb) begin
					e_q <= cmd.opb;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[sv/interval_set_tracker_unit.sv]
// ----------------------------------------------------------------------------
// interval_set_tracker_unit
// sorted table of disjoint inclusive intervals kept in a chain of cells
// ----------------------------------------------------------------------------
// req carries one item per operation (mode, offset, size); rsp returns results.
// one item is worked on at a time; req.ready is high only when idle.
// add: tests the table and merges or inserts, repeating the merge while it takes in
//   another entry, then loads the status result.
// truncate: drops entries from the top one at a time, then loads the status result.
// clear and range errors: go straight to the status result.
// walk: skips the entries below the query one at a time, then emits segments,
//   waiting while rsp stalls; up to 2*MAX_INTERVALS+1 segments, last marked.
// the entry cells compare against the operand in parallel and merges close
//   the gap one neighbor shift per cycle; walk reads the cells one at a time.
// a single output register sits on rsp; a stalled receiver holds the block
//   at the next result, and a new item is taken while the last result waits.
// reset empties the table and the output register; cell contents keep no
//   reset and are only read below the entry count.
// ----------------------------------------------------------------------------
module interval_set_tracker_unit import ist_pkg::*; #(
	parameter int MAX_INTERVALS = 16
) (
	input logic      clk,
	input logic      arst_n,
	ist_in_if.sink   req,
	ist_out_if.source rsp
);

	localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CW = $clog2(MAX_INTERVALS + 1);

	state_t          state_q;
	state_t          state_d;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   k_q;
	logic [CW-1:0]   cnt_m1;
	addr_t           b_q;
	addr_t           e_q;
	addr_t           cur_q;
	logic            gap_q;
	st_t             st_q;
	st_t             st_d;
	logic            st_ld;

	logic            out_v_q;
	addr_t           ob_q;
	addr_t           oe_q;
	logic            ocov_q;
	logic            olast_q;
	st_t             ost_q;

	cell_link_t      lnk [MAX_INTERVALS];
	logic [MAX_INTERVALS:0] shr;
	logic [MAX_INTERVALS:0] tany;
	cell_cmd_t       cmd;

	logic            acc;
	logic [ADDR_W:0] end_sum;
	logic            bad;
	logic            any_touch;
	logic            shrink;
	logic            full;
	logic            k_ok;
	logic            can_emit;
	logic [IW-1:0]   rd_idx;
	addr_t           rd_b;
	addr_t           rd_e;
	logic            in_rng;
	logic            gap_need;
	logic            end_hit;
	logic            trunc_drop;
	logic            skip;

	logic            emit;
	addr_t           o_b;
	addr_t           o_e;
	logic            o_cov;
	logic            o_last;
	st_t             o_st;
	logic            cnt_inc;
	logic            cnt_dec;
	logic            cnt_clr;
	logic            k_inc;
	logic            cur_ld;
	logic            gap_set;
	logic            gap_clr;

	// entry cells
	assign shr[0]  = 1'b0;
	assign tany[0] = 1'b0;

	for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
		cell_link_t lft;
		cell_link_t rgt;
		logic       vld;
		if (k == 0) begin : g_first
			assign lft = EDGE_LINK;
		end else begin : g_mid
			assign lft = lnk[k-1];
		end
		if (k == MAX_INTERVALS - 1) begin : g_last
			assign rgt = EDGE_LINK;
		end else begin : g_inner
			assign rgt = lnk[k+1];
		end
		assign vld = cnt_q > CW'(k);
		ist_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.valid      (vld),
			.left       (lft),
			.right      (rgt),
			.shrink_in  (shr[k]),
			.shrink_out (shr[k+1]),
			.tany_in    (tany[k]),
			.tany_out   (tany[k+1]),
			.self       (lnk[k])
		);
	end

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign end_sum   = {1'b0, req.offset} + (ADDR_W+1)'(req.size) - (ADDR_W+1)'(1);
	assign bad       = (req.size == '0) || end_sum[ADDR_W];

	assign any_touch  = tany[MAX_INTERVALS];
	assign shrink     = shr[MAX_INTERVALS];
	assign full       = (cnt_q == CW'(MAX_INTERVALS));
	assign k_ok       = (k_q < cnt_q);
	assign can_emit   = !out_v_q || rsp.ready;
	assign cnt_m1     = cnt_q - CW'(1);
	assign rd_idx     = (state_q == S_TRUNC) ? cnt_m1[IW-1:0] : k_q[IW-1:0];
	assign rd_b       = lnk[rd_idx].b;
	assign rd_e       = lnk[rd_idx].e;
	assign in_rng     = k_ok && (rd_b <= e_q);
	assign gap_need   = !gap_q && (rd_b > cur_q);
	assign end_hit    = (rd_e >= e_q);
	assign trunc_drop = (cnt_q != '0) && (rd_b > b_q);
	assign skip       = k_ok && (rd_e < b_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (mode_t'(req.mode))
						MODE_CLEAR: state_d = S_RESP;
						MODE_TRUNC: state_d = S_TRUNC;
						MODE_ADD:   state_d = bad ? S_RESP : S_ADD;
						MODE_WALK:  state_d = bad ? S_RESP : S_WSKIP;
						default:    state_d = S_RESP;
					endcase
				end
			end
			S_ADD: begin
				if (!any_touch || !shrink) state_d = S_RESP;
			end
			S_TRUNC: begin
				if (!trunc_drop) state_d = S_RESP;
			end
			S_WSKIP: begin
				if (!skip) state_d = S_WLOOP;
			end
			S_WLOOP: begin
				if (can_emit && (!in_rng || (!gap_need && end_hit))) state_d = S_IDLE;
			end
			S_RESP: begin
				if (can_emit) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd     = '{op: COP_HOLD, opb: b_q, ope: e_q};
		emit    = 1'b0;
		o_b     = '0;
		o_e     = '0;
		o_cov   = 1'b0;
		o_last  = 1'b0;
		o_st    = ST_OK;
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		cnt_clr = 1'b0;
		k_inc   = 1'b0;
		cur_ld  = 1'b0;
		gap_set = 1'b0;
		gap_clr = 1'b0;
		st_d    = ST_OK;
		st_ld   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					st_ld = 1'b1;
					if ((mode_t'(req.mode) == MODE_ADD || mode_t'(req.mode) == MODE_WALK)
							&& bad) begin
						st_d = ST_RANGE;
					end
					if (mode_t'(req.mode) == MODE_CLEAR) cnt_clr = 1'b1;
				end
			end
			S_ADD: begin
				if (any_touch) begin
					cmd.op = COP_MERGE;
					if (shrink) cnt_dec = 1'b1;
				end else if (full) begin
					st_d  = ST_FULL;
					st_ld = 1'b1;
				end else begin
					cmd.op  = COP_INSERT;
					cnt_inc = 1'b1;
				end
			end
			S_TRUNC: begin
				cmd.op = COP_TRUNC;
				if (trunc_drop) cnt_dec = 1'b1;
			end
			S_WSKIP: begin
				if (skip) k_inc = 1'b1;
			end
			S_WLOOP: begin
				if (can_emit) begin
					emit = 1'b1;
					if (!in_rng) begin
						o_b    = cur_q;
						o_e    = e_q;
						o_last = 1'b1;
					end else if (gap_need) begin
						o_b     = cur_q;
						o_e     = rd_b - ADDR_W'(1);
						gap_set = 1'b1;
					end else begin
						o_b    = (rd_b > cur_q) ? rd_b : cur_q;
						o_e    = (rd_e < e_q) ? rd_e : e_q;
						o_cov  = 1'b1;
						o_last = end_hit;
						if (!end_hit) begin
							cur_ld  = 1'b1;
							k_inc   = 1'b1;
							gap_clr = 1'b1;
						end
					end
				end
			end
			S_RESP: begin
				if (can_emit) begin
					emit   = 1'b1;
					o_last = 1'b1;
					o_st   = st_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
			gap_q   <= 1'b0;
			st_q    <= ST_OK;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_m1;
			end
			if (acc) begin
				k_q <= '0;
			end else if (k_inc) begin
				k_q <= k_q + CW'(1);
			end
			if (acc || gap_clr) begin
				gap_q <= 1'b0;
			end else if (gap_set) begin
				gap_q <= 1'b1;
			end
			if (st_ld) st_q <= st_d;
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			b_q   <= req.offset;
			e_q   <= end_sum[ADDR_W-1:0];
			cur_q <= req.offset;
		end else if (cur_ld) begin
			cur_q <= rd_e + ADDR_W'(1);
		end
		if (emit) begin
			ob_q    <= o_b;
			oe_q    <= o_e;
			ocov_q  <= o_cov;
			olast_q <= o_last;
			ost_q   <= o_st;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.seg_begin = ob_q;
	assign rsp.seg_end   = oe_q;
	assign rsp.covered   = ocov_q;
	assign rsp.last      = olast_q;
	assign rsp.status    = ost_q;

endmodule

[sv/ist_checker.sv]
// ----------------------------------------------------------------------------
// ist_checker
// port-level checks for the interval set tracker, bound to the top level
// ----------------------------------------------------------------------------
`include "interval_set_tracker_unit_macros.svh"

module ist_checker import ist_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input addr_t      seg_begin,
	input addr_t      seg_end,
	input logic       covered,
	input logic       last,
	input logic [1:0] status
);

	// stalled result holds
	`IST_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(seg_begin) && $stable(seg_end) && $stable(status) && $stable(last))

	// error results are bare status items
	`IST_ASSERT_NOW(a_err_form, out_valid && status != ST_OK, seg_begin == '0 && seg_end == '0 && !covered && last)

	// segments are never reversed
	`IST_ASSERT_NOW(a_seg_order, out_valid, seg_begin <= seg_end)

	// one item in work at a time
	`IST_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)

endmodule

bind interval_set_tracker_unit ist_checker u_ist_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.seg_begin (rsp.seg_begin),
	.seg_end   (rsp.seg_end),
	.covered   (rsp.covered),
	.last      (rsp.last),
	.status    (rsp.status)
);
